>>> rtl/sem_pkg.sv
// shared constants, types and helpers for the sobel edge magnitude stream
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

    localparam int unsigned MAX_COLS_DEF     = 2048;
    localparam int unsigned LW_W             = 12;
    localparam int unsigned FH_W             = 16;
    localparam int unsigned CFG_W            = 16;
    localparam int unsigned PIX_W            = 8;
    localparam int unsigned ROW_W            = 16;
    localparam int unsigned COL_W            = 11;
    localparam int unsigned IN_TDATA_W       = 24;
    localparam int unsigned OUT_TDATA_W      = 40;
    localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;
    localparam logic [PIX_W-1:0] SAT_MAX         = 8'd255;

    typedef enum logic [0:0] {
        CFG_LINE_WIDTH   = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              frame_end;
        logic [COL_W-1:0]  out_col;
        logic [ROW_W-1:0]  out_row;
        logic [PIX_W-1:0]  edge_res;
    } t_res;

    // floor(s / 3) for s up to 765 via reciprocal multiply
    function automatic logic [PIX_W-1:0] div3(input logic [9:0] s);
        logic [19:0] p;
        p = 20'(s) * 20'd683;
        return p[18:11];
    endfunction

endpackage
`default_nettype wire

>>> rtl/sem_line_ram.sv
// simple dual-port line store memory with registered read data
`timescale 1ns / 1ps
`default_nettype none
module sem_line_ram #(
    parameter  int unsigned DEPTH = 2048,
    parameter  int unsigned WIDTH = 16,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/sobel_edge_magnitude_stream.sv
// top level: gray conversion, line store, 3x3 sobel window and result queue
// path: the result for the item that completes a window passes the stage 1 registers and the result queue to m_axis
// throughput: one item per cycle while the result queue has room, set by the single read-modify-write of the line store
// the line store is read at accept and written back in the following cycle, with forwarding
// reset: counters, window and queue clear; line store columns at or above a fill count read as zero
// reset: line_width 640, frame_height 480; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude_stream
    import sem_pkg::*;
#(
    parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // blue[7:0], green[15:8], red[23:16]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // edge_res[7:0], out_row[23:8], out_col[34:24], zeros[39:35]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast
);

    localparam int unsigned CNT_W = $clog2(MAX_COLS);
    localparam int unsigned EW    = (CNT_W + 1 > LW_W) ? CNT_W + 1 : LW_W;
    localparam int unsigned MEM_W = 2 * PIX_W;

    // configuration
    logic [LW_W-1:0] r_line_width;
    logic [FH_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[LW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // stage 0: accept, position, gray, line store read
    logic accept;
    logic [CNT_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [EW-1:0]    w_eff;
    logic [FH_W-1:0]  h_eff;
    logic             last_col, last_row;
    logic [9:0]       rgb_sum;
    logic [PIX_W-1:0] gray;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign rgb_sum = 10'(s_axis_tdata[7:0]) + 10'(s_axis_tdata[15:8])
                   + 10'(s_axis_tdata[23:16]);
    assign gray    = div3(rgb_sum);

    always_comb begin
        w_eff = EW'(r_line_width);
        if (w_eff > EW'(MAX_COLS)) begin
            w_eff = EW'(MAX_COLS);
        end
        if (w_eff == '0) begin
            w_eff = EW'(1);
        end
        h_eff = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
        last_col = (EW'(r_col) + EW'(1)) >= w_eff;
        last_row = ({1'b0, r_row} + 17'd1) >= {1'b0, h_eff};
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + CNT_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1 registers
    logic             r_v1;
    logic             r_emit1;
    logic             r_rd_ok1;
    logic [CNT_W-1:0] r_c1;
    logic [PIX_W-1:0] r_gray1;
    logic [ROW_W-1:0] r_orow1;
    logic [COL_W-1:0] r_ocol1;
    logic             r_end1;
    logic [CNT_W:0]   r_fill;
    logic [CNT_W-1:0] col_m1;

    assign col_m1 = r_col - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_emit1  <= (r_row >= ROW_W'(2)) && (r_col >= CNT_W'(2));
            r_rd_ok1 <= {1'b0, r_col} < r_fill;
            r_c1     <= r_col;
            r_gray1  <= gray;
            r_orow1  <= r_row - ROW_W'(1);
            r_ocol1  <= COL_W'(col_m1);
            r_end1   <= last_col && last_row;
        end
    end

    // line store: {older row, newer row} per column
    logic [MEM_W-1:0] rd_data;
    logic [MEM_W-1:0] r_fw_data;
    logic [CNT_W-1:0] r_fw_addr;
    logic             r_fw_v;
    logic [PIX_W-1:0] top, mid;
    logic [MEM_W-1:0] wr_data;

    sem_line_ram #(
        .DEPTH (MAX_COLS),
        .WIDTH (MEM_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_v1),
        .i_waddr (r_c1),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rd_data)
    );

    always_comb begin
        if (r_fw_v && (r_fw_addr == r_c1)) begin
            {top, mid} = r_fw_data;
        end else if (r_rd_ok1) begin
            {top, mid} = rd_data;
        end else begin
            top = '0;
            mid = '0;
        end
    end

    assign wr_data = {mid, r_gray1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_v <= 1'b0;
            r_fill <= '0;
        end else if (r_v1) begin
            r_fw_v <= 1'b1;
            if ({1'b0, r_c1} >= r_fill) begin
                r_fill <= {1'b0, r_c1} + (CNT_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_fw_addr <= r_c1;
            r_fw_data <= wr_data;
        end
    end

    // window: column before last (p) and previous column (q), rows top to bottom
    logic [PIX_W-1:0] r_p [3];
    logic [PIX_W-1:0] r_q [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= '0;
                r_q[i] <= '0;
            end
        end else if (r_v1) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= r_q[i];
            end
            r_q[0] <= top;
            r_q[1] <= mid;
            r_q[2] <= r_gray1;
        end
    end

    // sobel gradients, l1 magnitude, saturation
    logic [9:0]        gx_a, gx_b, gy_a, gy_b;
    logic signed [11:0] gx, gy;
    logic [10:0]       ax, ay;
    logic [11:0]       mag;
    logic [PIX_W-1:0]  edge_val;

    always_comb begin
        gx_a = 10'(r_p[0]) + {1'b0, r_p[1], 1'b0} + 10'(r_p[2]);
        gx_b = 10'(top) + {1'b0, mid, 1'b0} + 10'(r_gray1);
        gy_a = 10'(r_p[0]) + {1'b0, r_q[0], 1'b0} + 10'(top);
        gy_b = 10'(r_p[2]) + {1'b0, r_q[2], 1'b0} + 10'(r_gray1);
        gx   = signed'({2'b00, gx_a}) - signed'({2'b00, gx_b});
        gy   = signed'({2'b00, gy_a}) - signed'({2'b00, gy_b});
        ax   = gx[11] ? 11'(-gx) : 11'(gx);
        ay   = gy[11] ? 11'(-gy) : 11'(gy);
        mag  = 12'(ax) + 12'(ay);
        edge_val = (mag > 12'(SAT_MAX)) ? SAT_MAX : mag[PIX_W-1:0];
    end

    // result queue
    t_res       r_q_res [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, pop;
    t_res       new_res;

    assign push = r_v1 && r_emit1;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_comb begin
        new_res.edge_res  = edge_val;
        new_res.out_row   = r_orow1;
        new_res.out_col   = r_ocol1;
        new_res.frame_end = r_end1;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_res[r_wp] <= new_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 3'd1;
                2'b01:   r_cnt <= r_cnt - 3'd1;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = ({1'b0, r_cnt} + {3'b000, r_v1}) <= 4'd3;
    assign m_axis_tvalid = r_cnt != '0;
    assign m_axis_tlast  = r_q_res[r_rp].frame_end;
    assign m_axis_tdata  = {5'b00000, r_q_res[r_rp].out_col, r_q_res[r_rp].out_row,
                            r_q_res[r_rp].edge_res};

endmodule
`default_nettype wire
